@@ design/awrs_pkg.sv @@
// shared constants for the windowed rms level meter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package awrs_pkg;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int FILL_W            = 17;   // window count, up to 65536
  localparam int TSUM_W            = 64;
  localparam int DC_W              = 48;
  localparam int OUT_DATA_W        = 160;
  localparam logic [15:0] WIN_SIZE_RESET = 16'd22050;
endpackage
`default_nettype wire

@@ design/awrs_queue.sv @@
// two-entry job queue between the accumulator front and the rms back end
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module awrs_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  valid,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       used;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      used <= used + 2'(push) - 2'(pop);
    end
  end

  assign full  = used == 2'd2;
  assign valid = used != 2'd0;
  assign rdata = mem[rptr];
endmodule
`default_nettype wire

@@ design/awrs_front.sv @@
// front end: takes samples, keeps window and stream sums, hands jobs to the queue
// depends on awrs_pkg
`timescale 1ns / 1ps
`default_nettype none
module awrs_front #(
  parameter int SAMPLE_BITS   = awrs_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = awrs_pkg::POSITION_BITS_DEF,
  parameter int WSUM_W        = 2 * SAMPLE_BITS + 15,
  parameter int JOB_W         = 2 + WSUM_W + awrs_pkg::FILL_W + 2 * POSITION_BITS
                                + awrs_pkg::TSUM_W + awrs_pkg::DC_W + 2 * SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [15:0]            cfg_wdata,
  input  wire logic                   accept,
  input  wire logic                   flush,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        push,
  output logic [JOB_W-1:0]            job
);
  import awrs_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PB = POSITION_BITS;

  logic [15:0]              window_size;
  logic [WSUM_W-1:0]        wsum;
  logic [FILL_W-1:0]        fill;
  logic [PB-1:0]            pos;
  logic [TSUM_W-1:0]        tsum;
  logic [DC_W-1:0]          dcs;
  logic signed [SB-1:0]     low;
  logic signed [SB-1:0]     high;

  logic signed [SB-1:0]     s;
  logic signed [2*SB-1:0]   prod;
  logic [FILL_W-1:0]        count;
  logic [FILL_W-1:0]        limit;
  logic                     close;
  logic [WSUM_W-1:0]        wsum_next;

  always_comb begin
    s         = signed'(sample);
    prod      = s * s;
    count     = fill + FILL_W'(1);
    limit     = (window_size == 16'd0) ? FILL_W'(17'h10000) : FILL_W'(window_size);
    close     = count >= limit;
    wsum_next = wsum + WSUM_W'(unsigned'(prod));
  end

  assign push = accept && (flush || close);

  // job layout, msb first: flush, partial, wsum, count, start, tsum, dc, tpos, low, high
  always_comb begin
    if (flush) begin
      job = {1'b1, fill != FILL_W'(0), wsum, fill, pos, tsum, dcs, pos + PB'(fill),
             low, high};
    end else begin
      job = {1'b0, 1'b1, wsum_next, count, pos, TSUM_W'(0), DC_W'(0), PB'(0),
             SB'(0), SB'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WIN_SIZE_RESET;
    end else if (cfg_wen) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && flush)) begin
      wsum <= '0;
      fill <= '0;
      pos  <= '0;
      tsum <= '0;
      dcs  <= '0;
      low  <= '0;
      high <= '0;
    end else if (accept) begin
      tsum <= tsum + TSUM_W'(unsigned'(prod));
      dcs  <= dcs + {{(DC_W-SB){s[SB-1]}}, s};
      if (s < low) low <= s;
      if (s > high) high <= s;
      if (close) begin
        wsum <= '0;
        fill <= '0;
        pos  <= pos + PB'(count);
      end else begin
        wsum <= wsum_next;
        fill <= count;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/awrs_back.sv @@
// back end: shared restoring divider and digit-pair square root, peak tracking,
// result register; depends on awrs_pkg
`timescale 1ns / 1ps
`default_nettype none
module awrs_back #(
  parameter int SAMPLE_BITS   = awrs_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = awrs_pkg::POSITION_BITS_DEF,
  parameter int WSUM_W        = 2 * SAMPLE_BITS + 15,
  parameter int JOB_W         = 2 + WSUM_W + awrs_pkg::FILL_W + 2 * POSITION_BITS
                                + awrs_pkg::TSUM_W + awrs_pkg::DC_W + 2 * SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire logic [JOB_W-1:0]               q_rdata,
  output logic                                q_pop,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [awrs_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import awrs_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int PB    = POSITION_BITS;
  localparam int DIV_W = (PB > FILL_W) ? PB : FILL_W;
  localparam logic [63:0] RMS_CAP = 64'(1) << (SB - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] PH_WIN = 2'd0;
  localparam logic [1:0] PH_TOT = 2'd1;
  localparam logic [1:0] PH_DC  = 2'd2;

  logic [2:0] state;
  logic [1:0] phase;

  // job fields
  logic                    j_flush, j_partial;
  logic [WSUM_W-1:0]       j_wsum;
  logic [FILL_W-1:0]       j_count;
  logic [PB-1:0]           j_start;
  logic [TSUM_W-1:0]       j_tsum;
  logic [DC_W-1:0]         j_dc;
  logic [PB-1:0]           j_tpos;
  logic [SB-1:0]           j_low, j_high;
  logic [JOB_W-1:0]        job;

  assign {j_flush, j_partial, j_wsum, j_count, j_start, j_tsum, j_dc, j_tpos,
          j_low, j_high} = job;

  // divider
  logic [63:0]      dvd;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W-1:0] rem;
  logic [63:0]      quo;
  logic [5:0]       dcnt;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [63:0]      quo_next;
  logic [63:0]      q_fin;
  logic [63:0]      div_a;
  logic [DIV_W-1:0] div_b;
  logic [DC_W-1:0]  dmag;

  // square root
  logic [63:0] sv, sres, sbit;
  logic [4:0]  scnt;
  logic [63:0] st, sv_next, sres_next, capped;
  logic        sge;

  logic [15:0]        win_rms, tot_rms, best_rms;
  logic signed [15:0] dc_res, dc_sat;
  logic [PB-1:0]      best_start;

  always_comb begin
    dmag = j_dc[DC_W-1] ? (DC_W'(0) - j_dc) : j_dc;
    case (phase)
      PH_WIN: begin
        div_a = 64'(j_wsum);
        div_b = DIV_W'(j_count);
      end
      PH_TOT: begin
        div_a = j_tsum;
        div_b = DIV_W'(j_tpos);
      end
      default: begin
        div_a = 64'(dmag);
        div_b = DIV_W'(j_tpos);
      end
    endcase
    trial    = {rem, dvd[63]};
    ge       = trial >= {1'b0, dvs};
    quo_next = {quo[62:0], ge};
    q_fin    = (dvs == '0) ? 64'd0 : quo_next;
    if (j_dc[DC_W-1]) begin
      dc_sat = (q_fin > 64'd32768) ? 16'sh8000 : 16'(-signed'(q_fin));
    end else begin
      dc_sat = (q_fin > 64'd32767) ? 16'sd32767 : 16'(q_fin);
    end
    st        = sres + sbit;
    sge       = sv >= st;
    sv_next   = sge ? sv - st : sv;
    sres_next = sge ? (sres >> 1) + sbit : sres >> 1;
    capped    = (sres_next > RMS_CAP) ? RMS_CAP : sres_next;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (q_valid) job <= q_rdata;
      S_LOAD: begin
        dvd  <= div_a;
        dvs  <= div_b;
        rem  <= '0;
        quo  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        dvd  <= dvd << 1;
        rem  <= ge ? DIV_W'(trial - {1'b0, dvs}) : DIV_W'(trial);
        quo  <= quo_next;
        dcnt <= dcnt + 6'd1;
        sv   <= q_fin;
        sres <= '0;
        sbit <= 64'(1) << 62;
        scnt <= '0;
        if (dcnt == 6'd63) dc_res <= dc_sat;
      end
      S_SQRT: begin
        sv   <= sv_next;
        sres <= sres_next;
        sbit <= sbit >> 2;
        scnt <= scnt + 5'd1;
        if (scnt == 5'd31) begin
          if (phase == PH_WIN) win_rms <= capped[15:0];
          else tot_rms <= capped[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_WIN;
      m_tvalid   <= 1'b0;
      best_rms   <= '0;
      best_start <= '0;
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            phase <= (q_rdata[JOB_W-1] && !q_rdata[JOB_W-2]) ? PH_TOT : PH_WIN;
            state <= S_LOAD;
          end
        end
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (dcnt == 6'd63) state <= (phase == PH_DC) ? S_OUT : S_SQRT;
        end
        S_SQRT: begin
          if (scnt == 5'd31) begin
            if (phase == PH_WIN) begin
              state <= S_OUT;
            end else begin
              phase <= PH_DC;
              state <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (phase == PH_WIN && j_flush) begin
              phase <= PH_TOT;
              state <= S_LOAD;
            end else if (phase == PH_WIN) begin
              if (win_rms > best_rms) begin
                best_rms   <= win_rms;
                best_start <= j_start;
              end
              state <= S_IDLE;
            end else begin
              best_rms   <= '0;
              best_start <= '0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      if (phase == PH_WIN) begin
        m_tuser <= 1'b0;
        m_tlast <= !j_flush;
        m_tdata <= {1'b0, 15'd0, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0,
                    32'(j_start), win_rms};
      end else begin
        m_tuser <= 1'b1;
        m_tlast <= 1'b1;
        m_tdata <= {1'b0, 15'(j_high), 16'(signed'(j_low)), 32'(best_start), best_rms,
                    dc_res, tot_rms, 32'd0, 16'd0};
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("queue popped while busy");
  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT) else $error("result raised outside output step");
  a_best_cap: assert property (@(posedge clk) disable iff (rst)
    64'(best_rms) <= RMS_CAP) else $error("peak rms above full scale");
  a_win_has_samples: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && phase == PH_WIN) |-> j_partial)
    else $error("window job without samples");
endmodule
`default_nettype wire

@@ design/audio_window_rms_statistics_core.sv @@
// top level of the windowed rms level meter
// depends on awrs_pkg, awrs_front, awrs_queue, awrs_back
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata                 | tuser       | tlast
// s_*     | in  | sample                | kind        | -
// m_*     | out | window/total fields   | result_kind | last_of_run
// cfg_*   | in  | window_size           | -           | -
//
// a sample goes into the front's registered sums; a window close or end of stream
// queues a job for the back end (two-entry queue)
// back end: a restoring divide (load, then shift steps) and a digit-pair root;
// a window result is one divide and one root; an end-of-stream item is a divide
// and root for the stream rms, then a divide for dc, after any partial window
// s_tready drops only while the queue is full; m_tready stalls only the back
// synchronous active-high reset, window_size returns to 22050
module audio_window_rms_statistics_core #(
  parameter int SAMPLE_BITS   = awrs_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = awrs_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wen,
  input  wire logic [15:0]                          cfg_wdata,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
  input  wire logic                                 s_tuser,   // kind
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // window_rms, window_start, stream rms, dc_offset, best window rms,
  // best window start, min_sample, max_sample, one pad bit
  output logic [awrs_pkg::OUT_DATA_W-1:0]           m_tdata,
  output logic                                      m_tuser,   // result_kind
  output logic                                      m_tlast    // last_of_run
);
  import awrs_pkg::*;

  localparam int WSUM_W = 2 * SAMPLE_BITS + 15;
  localparam int JOB_W  = 2 + WSUM_W + FILL_W + 2 * POSITION_BITS + TSUM_W + DC_W
                          + 2 * SAMPLE_BITS;

  logic             q_full, q_valid, q_push, q_pop, accept;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  // word taken whenever the queue can hold a job
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  awrs_front #(
    .SAMPLE_BITS(SAMPLE_BITS), .POSITION_BITS(POSITION_BITS),
    .WSUM_W(WSUM_W), .JOB_W(JOB_W)
  ) u_front (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .accept(accept), .flush(s_tuser), .sample(s_tdata[SAMPLE_BITS-1:0]),
    .push(q_push), .job(q_wdata)
  );

  awrs_queue #(.WIDTH(JOB_W)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .full(q_full), .valid(q_valid), .rdata(q_rdata)
  );

  awrs_back #(
    .SAMPLE_BITS(SAMPLE_BITS), .POSITION_BITS(POSITION_BITS),
    .WSUM_W(WSUM_W), .JOB_W(JOB_W)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_rdata(q_rdata), .q_pop(q_pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );
endmodule
`default_nettype wire

@@ tb/tb_audio_window_rms_statistics_core.sv @@
// testbench for the windowed rms level meter: drives samples and end-of-stream
// words, predicts window and total results and checks them in order
// depends on awrs_pkg and audio_window_rms_statistics_core
`timescale 1ns / 1ps

class rms_meter_scoreboard;
  // predicted result words: {last, kind, tdata}
  logic [161:0] pending[$];
  int           errors;
  // predictor state
  logic [15:0]  win_len;
  logic [63:0]  win_sq;
  logic [16:0]  win_fill;
  logic [31:0]  position;
  logic [63:0]  total_sq;
  logic [47:0]  dc_acc;
  logic signed [15:0] low_mark, high_mark;
  logic [15:0]  best_rms;
  logic [31:0]  best_start;

  function void clear_stats();
    win_sq = 0; win_fill = 0; position = 0; total_sq = 0; dc_acc = 0;
    low_mark = 0; high_mark = 0; best_rms = 0; best_start = 0;
  endfunction

  function void on_reset();
    win_len = awrs_pkg::WIN_SIZE_RESET;
    errors = 0;
    pending.delete();
    clear_stats();
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function logic [15:0] rms(logic [63:0] sq, logic [63:0] cnt);
    logic [63:0] r;
    if (cnt == 0) return 0;
    r = int_sqrt(sq / cnt);
    return (r > 64'd32768) ? 16'h8000 : r[15:0];
  endfunction

  function void push_window(logic [15:0] r, logic [31:0] start, logic last);
    logic [159:0] d;
    d = '0;
    d[15:0] = r;
    d[47:16] = start;
    pending.push_back({last, 1'b0, d});
  endfunction

  function void note_word(logic kind, logic [15:0] smp);
    logic signed [63:0] s;
    logic [63:0] limit, cnt, dmag, q;
    logic [15:0] r, dc;
    logic [159:0] d;
    logic neg;
    if (!kind) begin
      s = $signed(smp);
      limit = (win_len == 0) ? 64'd65536 : {48'd0, win_len};
      if (s < low_mark) low_mark = s[15:0];
      if (s > high_mark) high_mark = s[15:0];
      win_sq += s * s;
      total_sq += s * s;
      dc_acc += s[47:0];
      cnt = win_fill + 1;
      if (cnt >= limit) begin
        r = rms(win_sq, cnt);
        push_window(r, position, 1'b1);
        if (r > best_rms) begin
          best_rms = r;
          best_start = position;
        end
        position += cnt[31:0];
        win_fill = 0;
        win_sq = 0;
      end else begin
        win_fill = cnt[16:0];
      end
      return;
    end
    // end of stream: partial window first, then totals
    if (win_fill != 0) begin
      push_window(rms(win_sq, win_fill), position, 1'b0);
      position += win_fill;
    end
    neg = dc_acc[47];
    dmag = neg ? {16'd0, -dc_acc} : {16'd0, dc_acc};
    q = (position != 0) ? dmag / position : 0;
    if (neg) dc = (q > 32768) ? 16'h8000 : -q[15:0];
    else dc = (q > 32767) ? 16'h7fff : q[15:0];
    d = '0;
    d[63:48] = rms(total_sq, position);
    d[79:64] = dc;
    d[95:80] = best_rms;
    d[127:96] = best_start;
    d[143:128] = low_mark;
    d[158:144] = high_mark[14:0];
    pending.push_back({1'b1, 1'b1, d});
    clear_stats();
  endfunction

  function void check_word(logic last, logic kind, logic [159:0] d);
    logic [161:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result kind=%0d data=%h", $time, kind, d);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want[160] !== kind || want[161] !== last || want[159:0] !== d) begin
      $display("%0t: mismatch expected last=%0d kind=%0d data=%h", $time,
               want[161], want[160], want[159:0]);
      $display("%0t:          actual   last=%0d kind=%0d data=%h", $time,
               last, kind, d);
      errors++;
    end
  endfunction
endclass

module tb_audio_window_rms_statistics_core;
  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_wen = 0;
  logic [15:0]  cfg_wdata = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [15:0]  s_tdata = 0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [awrs_pkg::OUT_DATA_W-1:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  rms_meter_scoreboard meter = new();
  int send_idle_pct = 30;   // sender idle share in percent
  int recv_idle_pct = 65;   // receiver idle share in percent
  int quiet_cycles = 0;
  int in_count = 0;

  always #5 clk = ~clk;

  audio_window_rms_statistics_core i_dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // sample the result side and the watchdog at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) meter.check_word(m_tlast, m_tuser, m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // one word on the sample stream, with random gaps before it
  // valid stays high into the next word unless the sender idles or drains
  task automatic send_word(input logic kind, input logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    meter.note_word(kind, smp);
    in_count++;
    @(negedge clk);
  endtask

  // let all predicted results drain, then the back end settle
  task automatic drain();
    s_tvalid <= 0;
    while (meter.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic set_window(input logic [15:0] len);
    drain();
    cfg_wen <= 1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_wen <= 0;
    meter.win_len = len;
  endtask

  // small magnitudes half the time, else full scale or the extremes
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return $urandom_range(65535);
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  task automatic random_phase(input int words);
    int k;
    for (k = 0; k < words; k++) begin
      if ($urandom_range(39) == 0) send_word(1'b1, $urandom_range(65535));
      else send_word(1'b0, rand_sample());
    end
  endtask

  initial begin
    meter.on_reset();
    repeat (12) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: empty flush, extremes, partial window, peak ties
    send_word(1'b1, 16'h0);
    set_window(16'd4);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h7fff);
    send_word(1'b0, 16'h0000);
    send_word(1'b0, 16'hffff);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h8000);
    send_word(1'b1, 16'h5555);
    set_window(16'd1);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h0001);
    send_word(1'b1, 16'haaaa);
    // window lowered below the current fill
    set_window(16'd6);
    send_word(1'b0, 16'h1234);
    send_word(1'b0, 16'hedcb);
    send_word(1'b0, 16'h0100);
    set_window(16'd2);
    send_word(1'b0, 16'h7000);
    send_word(1'b1, 16'h0);
    // all negative stream, dc at the low end of its range
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h8000);
    send_word(1'b1, 16'hffff);

    // random phases across settings, idling patterns swapped
    set_window(16'd3);
    random_phase(300);
    send_word(1'b1, 16'h0);
    drain();   // sender holds until every result is back
    send_idle_pct = 65;
    recv_idle_pct = 30;
    set_window(16'd8);
    random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_window(16'd1);
    random_phase(150);
    set_window(16'd65535);
    random_phase(150);
    send_word(1'b1, 16'h0);
    set_window(16'd0);
    random_phase(50);
    send_word(1'b1, 16'h0);
    set_window(16'd5);
    random_phase(50);
    send_word(1'b1, 16'h0);

    drain();
    if (meter.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

@@ files.f @@
design/awrs_pkg.sv
design/awrs_queue.sv
design/awrs_front.sv
design/awrs_back.sv
design/audio_window_rms_statistics_core.sv
tb/tb_audio_window_rms_statistics_core.sv
